FILE: sv/fdc_pkg.sv
// Package: shared constants, types and helpers of the flow direction classifier.
`default_nettype none
package fdc_pkg;

  localparam int MAX_RULES  = 64;
  localparam int VLAN_SLOTS = 4096;
  localparam int RULE_AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W      = $clog2(MAX_RULES + 1);
  localparam int VLAN_AW    = (VLAN_SLOTS > 1) ? $clog2(VLAN_SLOTS) : 1;
  localparam int PREFIX_MAX = 32;

  typedef enum logic [1:0] {
    MODE_CLASSIFY = 2'd0,
    MODE_LOAD     = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PORT = 2'd0,
    KIND_VLAN = 2'd1,
    KIND_SRC  = 2'd2,
    KIND_DST  = 2'd3
  } kind_t;

  localparam logic [1:0] DIR_UNKNOWN = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [5:0]  plen;
    logic [15:0] tenant;
    logic [1:0]  dir;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic        found;
    logic [15:0] tenant;
    logic [1:0]  direction;
    logic        load_status;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_FETCH,
    ST_VLD,
    ST_DONE
  } state_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [5:0] sat;
    sat = (plen > 6'(PREFIX_MAX)) ? 6'(PREFIX_MAX) : plen;
    if (sat == 6'd0) begin
      prefix_mask = 32'h0;
    end else begin
      prefix_mask = 32'hFFFF_FFFF << (6'(PREFIX_MAX) - sat);
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/fdc_in_if.sv
// Interface: input transaction channel of the classifier.
`default_nettype none
interface fdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] pkt_port;
  logic [11:0] vlan_id;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] hint_tenant;
  logic [1:0]  hint_dir;
  logic [1:0]  rule_kind;
  logic [31:0] rule_key;
  logic [5:0]  rule_prefix_len;
  logic [15:0] rule_tenant;
  logic [1:0]  rule_direction;

  modport source (
    output valid, mode, pkt_port, vlan_id, src_ip, dst_ip, hint_tenant,
           hint_dir, rule_kind, rule_key, rule_prefix_len, rule_tenant,
           rule_direction,
    input  ready
  );
  modport sink (
    input  valid, mode, pkt_port, vlan_id, src_ip, dst_ip, hint_tenant,
           hint_dir, rule_kind, rule_key, rule_prefix_len, rule_tenant,
           rule_direction,
    output ready
  );
endinterface
`default_nettype wire

FILE: sv/fdc_out_if.sv
// Interface: result transaction channel of the classifier.
`default_nettype none
interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] tenant;
  logic [1:0]  direction;
  logic        load_status;

  modport source (output valid, found, tenant, direction, load_status, input ready);
  modport sink (input valid, found, tenant, direction, load_status, output ready);
endinterface
`default_nettype wire

FILE: sv/fdc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module fdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/flow_direction_classifier_core.sv
// Top level: first-match direction and tenant classifier around rule and VLAN memories.
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid / ready  | mode, packet fields, hint, rule fields
//  out_ch  | out | valid / ready  | found, tenant, direction, load_status
//  cfg     | in  | cfg_we         | cfg_wdata = unknown_port_code
//
// Classify with a known hint, load of a non-VLAN rule, full-table load, unused mode: straight to the result.
// VLAN rule load: map read, then conditional write.
// Classify by rules: scan of every loaded rule, then selection, then a rule fetch on a match only.
// Clear and reset both sweep the map one slot per cycle; a clear then replies, reset does not.
// A result waits in the output register; the block stalls only when a second one is ready.
`default_nettype none
module flow_direction_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fdc_in_if.sink           in_ch,
  fdc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  fdc_pkg::state_t state_r, state_nxt;

  logic [fdc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]                 unk_r;
  logic [fdc_pkg::VLAN_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic                        clr_reply_r, clr_reply_nxt;
  logic [15:0]                 port_r, port_nxt;
  logic [31:0]                 sip_r, sip_nxt;
  logic [31:0]                 dip_r, dip_nxt;
  logic                        vok_r, vok_nxt;
  logic [fdc_pkg::RULE_AW-1:0] scan_idx_r, scan_idx_nxt;
  logic                        port_hit_r, port_hit_nxt;
  logic [fdc_pkg::RULE_AW-1:0] port_idx_r, port_idx_nxt;
  logic                        src_hit_r, src_hit_nxt;
  logic [fdc_pkg::RULE_AW-1:0] src_idx_r, src_idx_nxt;
  logic                        dst_hit_r, dst_hit_nxt;
  logic [fdc_pkg::RULE_AW-1:0] dst_idx_r, dst_idx_nxt;
  logic [fdc_pkg::CNT_W-1:0]   ld_idx_r, ld_idx_nxt;
  logic [fdc_pkg::VLAN_AW-1:0] ld_vaddr_r, ld_vaddr_nxt;
  fdc_pkg::res_t               res_r, res_nxt;
  fdc_pkg::res_t               out_r;
  logic                        out_valid_r;

  logic                        rule_we, rule_re;
  logic [fdc_pkg::RULE_AW-1:0] rule_waddr, rule_raddr;
  fdc_pkg::rule_t              rule_wdata, rule_rdata;
  logic                        vmap_we, vmap_re;
  logic [fdc_pkg::VLAN_AW-1:0] vmap_waddr, vmap_raddr;
  logic [fdc_pkg::CNT_W-1:0]   vmap_wdata, vmap_rdata;

  logic                        accept;
  logic                        scan_last;
  logic                        out_free;
  logic                        win_hit;
  logic [fdc_pkg::RULE_AW-1:0] win_idx;
  logic                        vmap_hit;
  logic [fdc_pkg::CNT_W-1:0]   vmap_rule;
  logic [31:0]                 ent_mask;
  logic                        ent_port_hit, ent_src_hit, ent_dst_hit;

  fdc_ram #(.WIDTH(fdc_pkg::RULE_W), .DEPTH(fdc_pkg::MAX_RULES)) u_rule_mem (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .re    (rule_re),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  fdc_ram #(.WIDTH(fdc_pkg::CNT_W), .DEPTH(fdc_pkg::VLAN_SLOTS)) u_vlan_map (
    .clk   (clk),
    .we    (vmap_we),
    .waddr (vmap_waddr),
    .wdata (vmap_wdata),
    .re    (vmap_re),
    .raddr (vmap_raddr),
    .rdata (vmap_rdata)
  );

  assign in_ch.ready        = (state_r == fdc_pkg::ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.tenant      = out_r.tenant;
  assign out_ch.direction   = out_r.direction;
  assign out_ch.load_status = out_r.load_status;
  assign out_free           = !out_valid_r || out_ch.ready;

  assign scan_last = (fdc_pkg::CNT_W'({1'b0, scan_idx_r}) + 1'b1) == cnt_r;

  assign ent_mask     = fdc_pkg::prefix_mask(rule_rdata.plen);
  assign ent_port_hit = (rule_rdata.kind == fdc_pkg::KIND_PORT) && (port_r != unk_r) &&
                        (rule_rdata.key[15:0] == port_r);
  assign ent_src_hit  = (rule_rdata.kind == fdc_pkg::KIND_SRC) &&
                        ((sip_r & ent_mask) == rule_rdata.key);
  assign ent_dst_hit  = (rule_rdata.kind == fdc_pkg::KIND_DST) &&
                        ((dip_r & ent_mask) == rule_rdata.key);

  assign vmap_rule = vmap_rdata - 1'b1;
  assign vmap_hit  = vok_r && (vmap_rdata != '0) &&
                     ({1'b0, vmap_rule} < (fdc_pkg::CNT_W + 1)'(fdc_pkg::MAX_RULES));

  always_comb begin
    win_hit = 1'b1;
    win_idx = port_idx_r;
    if (port_hit_r) begin
      win_idx = port_idx_r;
    end else if (vmap_hit) begin
      win_idx = vmap_rule[fdc_pkg::RULE_AW-1:0];
    end else if (src_hit_r) begin
      win_idx = src_idx_r;
    end else if (dst_hit_r) begin
      win_idx = dst_idx_r;
    end else begin
      win_hit = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdc_pkg::ST_CLR: begin
        if (clr_addr_r == fdc_pkg::VLAN_AW'(fdc_pkg::VLAN_SLOTS - 1)) begin
          state_nxt = clr_reply_r ? fdc_pkg::ST_DONE : fdc_pkg::ST_IDLE;
        end
      end
      fdc_pkg::ST_IDLE: begin
        if (accept) begin
          case (fdc_pkg::mode_t'(in_ch.mode))
            fdc_pkg::MODE_CLASSIFY: begin
              if (in_ch.hint_dir != fdc_pkg::DIR_UNKNOWN) begin
                state_nxt = fdc_pkg::ST_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = fdc_pkg::ST_SEL;
              end else begin
                state_nxt = fdc_pkg::ST_SCAN;
              end
            end
            fdc_pkg::MODE_LOAD: begin
              if ({1'b0, cnt_r} >= (fdc_pkg::CNT_W + 1)'(fdc_pkg::MAX_RULES)) begin
                state_nxt = fdc_pkg::ST_DONE;
              end else if (in_ch.rule_kind == fdc_pkg::KIND_VLAN) begin
                state_nxt = fdc_pkg::ST_VLD;
              end else begin
                state_nxt = fdc_pkg::ST_DONE;
              end
            end
            fdc_pkg::MODE_CLEAR: state_nxt = fdc_pkg::ST_CLR;
            default:             state_nxt = fdc_pkg::ST_DONE;
          endcase
        end
      end
      fdc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = fdc_pkg::ST_SEL;
        end
      end
      fdc_pkg::ST_SEL:   state_nxt = win_hit ? fdc_pkg::ST_FETCH : fdc_pkg::ST_DONE;
      fdc_pkg::ST_FETCH: state_nxt = fdc_pkg::ST_DONE;
      fdc_pkg::ST_VLD:   state_nxt = fdc_pkg::ST_DONE;
      fdc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fdc_pkg::ST_CLR;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    port_nxt      = port_r;
    sip_nxt       = sip_r;
    dip_nxt       = dip_r;
    vok_nxt       = vok_r;
    scan_idx_nxt  = scan_idx_r;
    port_hit_nxt  = port_hit_r;
    port_idx_nxt  = port_idx_r;
    src_hit_nxt   = src_hit_r;
    src_idx_nxt   = src_idx_r;
    dst_hit_nxt   = dst_hit_r;
    dst_idx_nxt   = dst_idx_r;
    ld_idx_nxt    = ld_idx_r;
    ld_vaddr_nxt  = ld_vaddr_r;
    res_nxt       = res_r;
    rule_we       = 1'b0;
    rule_waddr    = cnt_r[fdc_pkg::RULE_AW-1:0];
    rule_wdata    = '0;
    rule_re       = 1'b0;
    rule_raddr    = '0;
    vmap_we       = 1'b0;
    vmap_waddr    = clr_addr_r;
    vmap_wdata    = '0;
    vmap_re       = 1'b0;
    vmap_raddr    = in_ch.vlan_id[fdc_pkg::VLAN_AW-1:0];
    case (state_r)
      fdc_pkg::ST_CLR: begin
        vmap_we = 1'b1;
        if (clr_addr_r == fdc_pkg::VLAN_AW'(fdc_pkg::VLAN_SLOTS - 1)) begin
          clr_addr_nxt  = '0;
          clr_reply_nxt = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      fdc_pkg::ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          case (fdc_pkg::mode_t'(in_ch.mode))
            fdc_pkg::MODE_CLASSIFY: begin
              if (in_ch.hint_dir != fdc_pkg::DIR_UNKNOWN) begin
                res_nxt.found     = 1'b1;
                res_nxt.tenant    = in_ch.hint_tenant;
                res_nxt.direction = in_ch.hint_dir;
              end else begin
                port_nxt     = in_ch.pkt_port;
                sip_nxt      = in_ch.src_ip;
                dip_nxt      = in_ch.dst_ip;
                vok_nxt      = {1'b0, in_ch.vlan_id} < 13'(fdc_pkg::VLAN_SLOTS);
                scan_idx_nxt = '0;
                port_hit_nxt = 1'b0;
                src_hit_nxt  = 1'b0;
                dst_hit_nxt  = 1'b0;
                rule_re      = 1'b1;
                vmap_re      = 1'b1;
              end
            end
            fdc_pkg::MODE_LOAD: begin
              if ({1'b0, cnt_r} >= (fdc_pkg::CNT_W + 1)'(fdc_pkg::MAX_RULES)) begin
                res_nxt.load_status = 1'b1;
              end else begin
                rule_we           = 1'b1;
                rule_wdata.kind   = in_ch.rule_kind;
                rule_wdata.tenant = in_ch.rule_tenant;
                rule_wdata.dir    = in_ch.rule_direction;
                if (in_ch.rule_kind == fdc_pkg::KIND_SRC ||
                    in_ch.rule_kind == fdc_pkg::KIND_DST) begin
                  rule_wdata.plen = (in_ch.rule_prefix_len > 6'(fdc_pkg::PREFIX_MAX)) ?
                                    6'(fdc_pkg::PREFIX_MAX) : in_ch.rule_prefix_len;
                  rule_wdata.key  = in_ch.rule_key &
                                    fdc_pkg::prefix_mask(in_ch.rule_prefix_len);
                end else begin
                  rule_wdata.key = {16'h0, in_ch.rule_key[15:0]};
                end
                cnt_nxt      = cnt_r + 1'b1;
                ld_idx_nxt   = cnt_r + 1'b1;
                ld_vaddr_nxt = in_ch.rule_key[fdc_pkg::VLAN_AW-1:0];
                vok_nxt      = {1'b0, in_ch.rule_key[15:0]} < 17'(fdc_pkg::VLAN_SLOTS);
                vmap_re      = 1'b1;
                vmap_raddr   = in_ch.rule_key[fdc_pkg::VLAN_AW-1:0];
              end
            end
            fdc_pkg::MODE_CLEAR: begin
              cnt_nxt       = '0;
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
            end
            default: res_nxt = '0;
          endcase
        end
      end
      fdc_pkg::ST_SCAN: begin
        if (ent_port_hit && !port_hit_r) begin
          port_hit_nxt = 1'b1;
          port_idx_nxt = scan_idx_r;
        end
        if (ent_src_hit && !src_hit_r) begin
          src_hit_nxt = 1'b1;
          src_idx_nxt = scan_idx_r;
        end
        if (ent_dst_hit && !dst_hit_r) begin
          dst_hit_nxt = 1'b1;
          dst_idx_nxt = scan_idx_r;
        end
        scan_idx_nxt = scan_idx_r + 1'b1;
        rule_re      = !scan_last;
        rule_raddr   = scan_idx_r + 1'b1;
      end
      fdc_pkg::ST_SEL: begin
        rule_re    = win_hit;
        rule_raddr = win_idx;
        res_nxt    = '0;
      end
      fdc_pkg::ST_FETCH: begin
        res_nxt.found     = 1'b1;
        res_nxt.tenant    = rule_rdata.tenant;
        res_nxt.direction = rule_rdata.dir;
      end
      fdc_pkg::ST_VLD: begin
        vmap_we    = vok_r && (vmap_rdata == '0);
        vmap_waddr = ld_vaddr_r;
        vmap_wdata = ld_idx_r;
      end
      fdc_pkg::ST_DONE: res_nxt = res_r;
      default:          res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdc_pkg::ST_CLR;
      cnt_r       <= '0;
      unk_r       <= 16'hFFFF;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      if (cfg_we) begin
        unk_r <= cfg_wdata;
      end
      if (state_r == fdc_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    port_r     <= port_nxt;
    sip_r      <= sip_nxt;
    dip_r      <= dip_nxt;
    vok_r      <= vok_nxt;
    scan_idx_r <= scan_idx_nxt;
    port_hit_r <= port_hit_nxt;
    port_idx_r <= port_idx_nxt;
    src_hit_r  <= src_hit_nxt;
    src_idx_r  <= src_idx_nxt;
    dst_hit_r  <= dst_hit_nxt;
    dst_idx_r  <= dst_idx_nxt;
    ld_idx_r   <= ld_idx_nxt;
    ld_vaddr_r <= ld_vaddr_nxt;
    res_r      <= res_nxt;
    if (state_r == fdc_pkg::ST_DONE && out_free) begin
      out_r <= res_r;
    end
  end

endmodule
`default_nettype wire
